// ===== design/ccmd_pkg.sv =====
// Shared types, widths and constants for the core clock and MDC divider calculator.
// No dependencies; every other design file refers to this package by scoped name.
package ccmd_pkg;

  // Field and datapath widths
  localparam int OscW      = 27;
  localparam int MulW      = 9;
  localparam int MdivW     = 6;
  localparam int DividendW = OscW + MulW;  // full-width source * N
  localparam int DivisorW  = 9;            // M * P tops out at 63 * 8
  localparam int DivSteps  = DividendW;    // one quotient bit per cell
  localparam int ClkW      = 32;

  // Register indexes on the configuration port
  localparam logic REG_EXTERNAL_OSC = 1'b0;
  localparam logic REG_INTERNAL_OSC = 1'b1;

  // Register reset values
  localparam logic [OscW-1:0] EXTERNAL_OSC_RESET = 27'd8000000;
  localparam logic [OscW-1:0] INTERNAL_OSC_RESET = 27'd16000000;

  // Status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TOO_LOW  = 2'd1;
  localparam logic [1:0] STATUS_TOO_HIGH = 2'd2;

  // MDC range setting when no entry fits
  localparam logic [2:0] MDC_NONE = 3'd6;

  // Lowest usable bus clock
  localparam logic [ClkW-1:0] MIN_BUS_HZ = 32'd25000000;

  // MDC table: clk / ratio <= 2375000 holds exactly when clk < 2375001 * ratio,
  // so each entry keeps that bound in place of its ratio.
  localparam int MdcEntries = 6;
  localparam logic [ClkW-1:0] MDC_BOUND [MdcEntries] = '{
    32'd38000016,   // ratio 16
    32'd61750026,   // ratio 26
    32'd99750042,   // ratio 42
    32'd147250062,  // ratio 62
    32'd242250102,  // ratio 102
    32'd294500124   // ratio 124
  };
  localparam logic [2:0] MDC_CODE [MdcEntries] = '{
    3'd2, 3'd3, 3'd0, 3'd1, 3'd4, 3'd5
  };

  // One beat moving down the divider chain
  typedef struct packed {
    logic [DivisorW-1:0]  rem;
    logic [DividendW-1:0] quo;
    logic [DivisorW-1:0]  divisor;
    logic [3:0]           ahb_prescaler;
  } div_beat_t;

  // Right shift applied by the AHB prescaler code
  function automatic logic [3:0] ahb_shift(input logic [3:0] code);
    logic [3:0] amount;
    amount = 4'd0;
    if (code[3]) begin
      case (code[2:0])
        3'd0: amount = 4'd1;
        3'd1: amount = 4'd2;
        3'd2: amount = 4'd3;
        3'd3: amount = 4'd4;
        3'd4: amount = 4'd6;
        3'd5: amount = 4'd7;
        3'd6: amount = 4'd8;
        3'd7: amount = 4'd9;
        default: amount = 4'd0;
      endcase
    end
    return amount;
  endfunction

endpackage

// ===== design/core_clock_and_mdc_divider_calc.sv =====
// Top level of the core clock and MDC divider calculator.
// Depends on ccmd_pkg, ccmd_front, ccmd_div_cell and ccmd_grade.
//
//   channel | signals                          | beat moves when
//   --------+----------------------------------+------------------------
//   in      | in_valid/in_ready + six fields   | in_valid && in_ready
//   out     | out_valid/out_ready + three flds | out_valid && out_ready
//   cfg     | cfg_we, cfg_index, cfg_data      | cfg_we
//
// One beat enters per cycle while the output is not stalled; each result passes
// one input stage, 36 division cells and two grading stages.
// The chain of division cells, one quotient bit per cell, sets the latency.
// A stalled output holds the whole pipeline; in_ready follows that stall.
// Reset empties the pipeline and restores the oscillator registers.
module core_clock_and_mdc_divider_calc (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    clock_source_status,
  input  logic [3:0]                    ahb_prescaler,
  input  logic [ccmd_pkg::MdivW-1:0]    pll_input_divider,
  input  logic [ccmd_pkg::MulW-1:0]     pll_multiplier,
  input  logic [1:0]                    pll_output_div_code,
  input  logic                          pll_from_external,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ccmd_pkg::ClkW-1:0]     core_clock_hz,
  output logic [2:0]                    mdc_divider_setting,
  output logic [1:0]                    status,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [ccmd_pkg::OscW-1:0]     cfg_data
);

  logic                      advance;
  logic [ccmd_pkg::OscW-1:0] external_osc_hz;
  logic [ccmd_pkg::OscW-1:0] internal_osc_hz;
  logic                      chain_valid [ccmd_pkg::DivSteps+1];
  ccmd_pkg::div_beat_t       chain_data  [ccmd_pkg::DivSteps+1];

  // Move every stage unless the result register is full and stalled
  assign advance  = ~out_valid | out_ready;
  assign in_ready = advance;

  // Oscillator registers
  always_ff @(posedge clk) begin
    if (rst) begin
      external_osc_hz <= ccmd_pkg::EXTERNAL_OSC_RESET;
      internal_osc_hz <= ccmd_pkg::INTERNAL_OSC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ccmd_pkg::REG_EXTERNAL_OSC: external_osc_hz <= cfg_data;
        ccmd_pkg::REG_INTERNAL_OSC: internal_osc_hz <= cfg_data;
        default: ;
      endcase
    end
  end

  ccmd_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .advance             (advance),
    .in_valid            (in_valid),
    .clock_source_status (clock_source_status),
    .ahb_prescaler       (ahb_prescaler),
    .pll_input_divider   (pll_input_divider),
    .pll_multiplier      (pll_multiplier),
    .pll_output_div_code (pll_output_div_code),
    .pll_from_external   (pll_from_external),
    .external_osc_hz     (external_osc_hz),
    .internal_osc_hz     (internal_osc_hz),
    .out_valid           (chain_valid[0]),
    .out_data            (chain_data[0])
  );

  // Division chain, one cell per quotient bit
  for (genvar g = 0; g < ccmd_pkg::DivSteps; g++) begin : g_cell
    ccmd_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_valid  (chain_valid[g]),
      .in_data   (chain_data[g]),
      .out_valid (chain_valid[g+1]),
      .out_data  (chain_data[g+1])
    );
  end

  ccmd_grade u_grade (
    .clk                 (clk),
    .rst                 (rst),
    .advance             (advance),
    .in_valid            (chain_valid[ccmd_pkg::DivSteps]),
    .in_data             (chain_data[ccmd_pkg::DivSteps]),
    .out_valid           (out_valid),
    .core_clock_hz       (core_clock_hz),
    .mdc_divider_setting (mdc_divider_setting),
    .status              (status)
  );

endmodule

// ===== design/ccmd_front.sv =====
// Input stage: picks the clock source and forms dividend and divisor for the chain.
// Depends on ccmd_pkg.
module ccmd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          in_valid,
  input  logic [1:0]                    clock_source_status,
  input  logic [3:0]                    ahb_prescaler,
  input  logic [ccmd_pkg::MdivW-1:0]    pll_input_divider,
  input  logic [ccmd_pkg::MulW-1:0]     pll_multiplier,
  input  logic [1:0]                    pll_output_div_code,
  input  logic                          pll_from_external,
  input  logic [ccmd_pkg::OscW-1:0]     external_osc_hz,
  input  logic [ccmd_pkg::OscW-1:0]     internal_osc_hz,
  output logic                          out_valid,
  output ccmd_pkg::div_beat_t           out_data
);

  logic [ccmd_pkg::OscW-1:0]      pll_src;
  logic [2:0]                     p_half;
  logic [7:0]                     m_times_p_half;
  logic [ccmd_pkg::DividendW-1:0] dividend;
  logic [ccmd_pkg::DivisorW-1:0]  divisor;

  // Select source; plain oscillators pass through the chain divided by one
  always_comb begin
    pll_src        = pll_from_external ? external_osc_hz : internal_osc_hz;
    p_half         = {1'b0, pll_output_div_code} + 3'd1;
    m_times_p_half = 8'(pll_input_divider) * 8'(p_half);
    dividend       = ccmd_pkg::DividendW'(internal_osc_hz);
    divisor        = ccmd_pkg::DivisorW'(1);
    if (clock_source_status[0]) begin
      dividend = ccmd_pkg::DividendW'(external_osc_hz);
    end else if (clock_source_status[1]) begin
      if (pll_input_divider == '0) begin
        dividend = '0;
      end else begin
        // (src * N / M) / P equals src * N / (M * P) in floor division
        dividend = ccmd_pkg::DividendW'(pll_src) * ccmd_pkg::DividendW'(pll_multiplier);
        divisor  = {m_times_p_half, 1'b0};
      end
    end
  end

  // Register the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      out_data.rem           <= '0;
      out_data.quo           <= dividend;
      out_data.divisor       <= divisor;
      out_data.ahb_prescaler <= ahb_prescaler;
    end
  end

endmodule

// ===== design/ccmd_div_cell.sv =====
// One restoring-division cell: settles one quotient bit and hands the beat on.
// Depends on ccmd_pkg.
module ccmd_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                in_valid,
  input  ccmd_pkg::div_beat_t in_data,
  output logic                out_valid,
  output ccmd_pkg::div_beat_t out_data
);

  logic [ccmd_pkg::DivisorW:0]   trial;
  logic [ccmd_pkg::DivisorW:0]   diff;
  logic                          qbit;
  logic [ccmd_pkg::DivisorW-1:0] rem_next;

  // Bring down the next dividend bit and try the subtract
  always_comb begin
    trial = {in_data.rem, in_data.quo[ccmd_pkg::DividendW-1]};
    diff  = trial - {1'b0, in_data.divisor};
    qbit  = ~diff[ccmd_pkg::DivisorW];
    rem_next = qbit ? diff[ccmd_pkg::DivisorW-1:0] : trial[ccmd_pkg::DivisorW-1:0];
  end

  // Hold the partial remainder; shift the quotient bit in from the right
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      out_data.rem           <= rem_next;
      out_data.quo           <= {in_data.quo[ccmd_pkg::DividendW-2:0], qbit};
      out_data.divisor       <= in_data.divisor;
      out_data.ahb_prescaler <= in_data.ahb_prescaler;
    end
  end

endmodule

// ===== design/ccmd_grade.sv =====
// Output stages: prescaler shift and saturation, then MDC range and status.
// Depends on ccmd_pkg.
module ccmd_grade (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          in_valid,
  input  ccmd_pkg::div_beat_t           in_data,
  output logic                          out_valid,
  output logic [ccmd_pkg::ClkW-1:0]     core_clock_hz,
  output logic [2:0]                    mdc_divider_setting,
  output logic [1:0]                    status
);

  logic [ccmd_pkg::DividendW-1:0] shifted;
  logic [ccmd_pkg::ClkW-1:0]      bus_hz_next;
  logic [ccmd_pkg::ClkW-1:0]      bus_hz;
  logic                           bus_valid;
  logic [2:0]                     setting_next;
  logic [1:0]                     status_next;

  // Apply prescaler, clamp to 32 bits
  always_comb begin
    shifted = in_data.quo >> ccmd_pkg::ahb_shift(in_data.ahb_prescaler);
    if (|shifted[ccmd_pkg::DividendW-1:ccmd_pkg::ClkW]) begin
      bus_hz_next = '1;
    end else begin
      bus_hz_next = shifted[ccmd_pkg::ClkW-1:0];
    end
  end

  // Pick the first table entry that fits; walk backward so the first wins
  always_comb begin
    setting_next = ccmd_pkg::MDC_NONE;
    status_next  = ccmd_pkg::STATUS_TOO_HIGH;
    if (bus_hz < ccmd_pkg::MIN_BUS_HZ) begin
      status_next = ccmd_pkg::STATUS_TOO_LOW;
    end else begin
      for (int i = ccmd_pkg::MdcEntries - 1; i >= 0; i--) begin
        if (bus_hz < ccmd_pkg::MDC_BOUND[i]) begin
          setting_next = ccmd_pkg::MDC_CODE[i];
          status_next  = ccmd_pkg::STATUS_OK;
        end
      end
    end
  end

  // Advance both stages together
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      bus_valid <= in_valid;
      out_valid <= bus_valid;
    end
    if (advance) begin
      bus_hz              <= bus_hz_next;
      core_clock_hz       <= bus_hz;
      mdc_divider_setting <= setting_next;
      status              <= status_next;
    end
  end

endmodule
